[rtl/core/tcsp_pkg.sv]
// shared types and constants of the telnet command stream parser
package tcsp_pkg;

    // telnet command codes
    localparam logic [7:0] CODE_IAC  = 8'd255;
    localparam logic [7:0] CODE_SB   = 8'd250;
    localparam logic [7:0] CODE_SE   = 8'd240;
    localparam logic [7:0] CODE_WILL = 8'd251;
    localparam logic [7:0] CODE_DONT = 8'd254;

    // result kinds
    localparam logic [2:0] KIND_DATA  = 3'd0;
    localparam logic [2:0] KIND_NEG   = 3'd1;
    localparam logic [2:0] KIND_SBHDR = 3'd2;
    localparam logic [2:0] KIND_PARAM = 3'd3;
    localparam logic [2:0] KIND_SBEND = 3'd4;

    // output queue geometry
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] payload_byte;
        logic [7:0] verb_code;
        logic [7:0] option_code;
        logic       last;
    } result_t;

    // up to two results from one input byte, first one in r0
    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t r0;
        result_t r1;
    } push_t;

endpackage

[rtl/core/tcsp_decode.sv]
// telnet command decoder: parse state and result forming for one byte
module tcsp_decode
    import tcsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    output push_t      push
);

    typedef enum logic [6:0] {
        PH_NORMAL   = 7'b0000001,
        PH_IAC      = 7'b0000010,
        PH_VERB     = 7'b0000100,
        PH_SB_OPT   = 7'b0001000,
        PH_SB_SUB   = 7'b0010000,
        PH_SB_PARAM = 7'b0100000,
        PH_SB_IAC   = 7'b1000000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] verb_reg, verb_next;
    logic [7:0] option_reg, option_next;

    function automatic result_t mk(input logic [2:0] k, input logic [7:0] p,
                                   input logic [7:0] v, input logic [7:0] o,
                                   input logic l);
        result_t r;
        r.kind         = k;
        r.payload_byte = p;
        r.verb_code    = v;
        r.option_code  = o;
        r.last         = l;
        return r;
    endfunction

    always_comb
    begin
        phase_next  = phase_reg;
        verb_next   = verb_reg;
        option_next = option_reg;
        push        = '0;
        if (in_valid)
        begin
            unique case (phase_reg)
                PH_NORMAL:
                begin
                    if (in_byte == CODE_IAC)
                    begin
                        phase_next = PH_IAC;
                    end
                    else
                    begin
                        push.push0 = 1'b1;
                        push.r0    = mk(KIND_DATA, in_byte, 8'd0, 8'd0, 1'b1);
                    end
                end
                PH_IAC:
                begin
                    priority if (in_byte == CODE_IAC)
                    begin
                        phase_next = PH_NORMAL;
                        push.push0 = 1'b1;
                        push.r0    = mk(KIND_DATA, CODE_IAC, 8'd0, 8'd0, 1'b1);
                    end
                    else if (in_byte >= CODE_WILL && in_byte <= CODE_DONT)
                    begin
                        verb_next  = in_byte;
                        phase_next = PH_VERB;
                    end
                    else if (in_byte == CODE_SB)
                    begin
                        phase_next = PH_SB_OPT;
                    end
                    else
                    begin
                        // unknown two-byte command is dropped
                        phase_next = PH_NORMAL;
                    end
                end
                PH_VERB:
                begin
                    phase_next = PH_NORMAL;
                    push.push0 = 1'b1;
                    push.r0    = mk(KIND_NEG, 8'd0, verb_reg, in_byte, 1'b1);
                end
                PH_SB_OPT:
                begin
                    option_next = in_byte;
                    phase_next  = PH_SB_SUB;
                end
                PH_SB_SUB:
                begin
                    verb_next  = in_byte;
                    phase_next = PH_SB_PARAM;
                    push.push0 = 1'b1;
                    push.r0    = mk(KIND_SBHDR, 8'd0, in_byte, option_reg, 1'b1);
                end
                PH_SB_PARAM:
                begin
                    if (in_byte == CODE_IAC)
                    begin
                        phase_next = PH_SB_IAC;
                    end
                    else
                    begin
                        push.push0 = 1'b1;
                        push.r0    = mk(KIND_PARAM, in_byte, verb_reg, option_reg, 1'b1);
                    end
                end
                PH_SB_IAC:
                begin
                    priority if (in_byte == CODE_SE)
                    begin
                        phase_next = PH_NORMAL;
                        push.push0 = 1'b1;
                        push.r0    = mk(KIND_SBEND, 8'd0, verb_reg, option_reg, 1'b1);
                    end
                    else if (in_byte == CODE_IAC)
                    begin
                        // escaped 0xff, the second iac may still open iac se
                        push.push0 = 1'b1;
                        push.r0    = mk(KIND_PARAM, CODE_IAC, verb_reg, option_reg, 1'b1);
                    end
                    else
                    begin
                        phase_next = PH_SB_PARAM;
                        push.push0 = 1'b1;
                        push.push1 = 1'b1;
                        push.r0    = mk(KIND_PARAM, CODE_IAC, verb_reg, option_reg, 1'b0);
                        push.r1    = mk(KIND_PARAM, in_byte, verb_reg, option_reg, 1'b1);
                    end
                end
                default:
                begin
                    phase_next = PH_NORMAL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_NORMAL;
            verb_reg   <= 8'd0;
            option_reg <= 8'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            verb_reg   <= verb_next;
            option_reg <= option_next;
        end
    end

    a_verb_gives_neg: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && phase_reg == PH_VERB) |-> (push.push0 && push.r0.kind == KIND_NEG))
        else $error("negotiation byte gave no negotiation result");

    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        push.push1 |-> (push.push0 && !push.r0.last && push.r1.last))
        else $error("two-result beat has wrong last marks");

    a_idle_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid |-> (!push.push0 && !push.push1 && phase_next == phase_reg))
        else $error("decoder moved without an input beat");

endmodule

[rtl/core/tcsp_outq.sv]
// small result queue taking up to two results a cycle and giving one while out_ready is high
module tcsp_outq
    import tcsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    result_t            mem [OQ_DEPTH];
    logic [OQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OQ_CW-1:0]   count_reg, count_next;
    logic               pop;
    logic [OQ_CW-1:0]   n_push;

    assign out_valid = (count_reg != '0);
    assign out_res   = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // room for a two-result beat
    assign room      = (count_reg <= OQ_CW'(OQ_DEPTH - 2));
    assign n_push    = OQ_CW'(push.push0) + OQ_CW'(push.push1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OQ_AW'(n_push);
        rd_ptr_next = rd_ptr_reg + OQ_AW'(pop);
        count_next  = count_reg + n_push - OQ_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.push1)
        begin
            mem[wr_ptr_reg + OQ_AW'(1)] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.push0 |-> (count_reg <= OQ_CW'(OQ_DEPTH - 2)))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= OQ_CW'(OQ_DEPTH))
        else $error("result queue count out of range");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        OQ_AW'(wr_ptr_reg - rd_ptr_reg) == OQ_AW'(count_reg))
        else $error("queue pointers disagree with count");

endmodule

[rtl/core/telnet_command_stream_parser.sv]
// top level of the telnet command stream parser
// The parser takes one telnet byte per beat on the slave side and sorts it into
// result beats on the master side: plain data bytes (iac iac folds to one 0xff),
// option negotiation events (iac will/wont/do/dont plus option), subnegotiation
// headers (iac sb, option, subcommand), raw parameter bytes and an end event at
// iac se; other two-byte iac commands are dropped. A subnegotiation without se
// stays open. Each input byte gives zero, one or two results, tlast marking the
// last result of that byte. The decoder works on a byte in the cycle it is
// accepted and writes its results into a four-entry result queue; a byte is
// taken every cycle while the queue holds two or fewer results; the block runs
// at one byte per cycle while the queue has room; when bytes give two results,
// the single-port read of the queue (one result beat per cycle) sets the rate.
module telnet_command_stream_parser
    import tcsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // payload_byte, verb_code, option_code
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast    // last result of the input byte
);

    push_t   push;
    result_t head;
    logic    in_fire;

    // a beat is taken only when the queue can hold both results it may cause
    assign in_fire = s_tvalid && s_tready;

    tcsp_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_fire),
        .in_byte  (s_tdata),
        .push     (push)
    );

    tcsp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (head)
    );

    // pack result fields onto the master side
    assign m_tdata = {head.option_code, head.verb_code, head.payload_byte};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

[tb/telnet_command_stream_parser_test.sv]
// self-checking testbench of the telnet command stream parser
module telnet_command_stream_parser_test;
    import tcsp_pkg::*;

    // telnet verbs and commands the package does not name
    localparam logic [7:0] CODE_WONT = 8'd252;
    localparam logic [7:0] CODE_DO   = 8'd253;
    localparam logic [7:0] CODE_NOP  = 8'd241;

    localparam int PHASE_BYTES = 125;   // at least this many random bytes per idling phase
    localparam int REPORT_MAX  = 10;

    // where the parser stands in the byte stream
    typedef enum logic [2:0] {
        ST_TEXT,      // plain data
        ST_IAC,       // iac seen, command byte next
        ST_OPT,       // negotiation verb seen, option next
        ST_SB_OPT,    // iac sb seen, option next
        ST_SB_CMD,    // subnegotiation option seen, subcommand next
        ST_SB_ARG,    // inside a subnegotiation, parameters
        ST_SB_IAC     // iac inside a subnegotiation
    } parse_state_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // stimulus and prediction
    logic [7:0]   pending_bytes [$];
    result_t      results_due [$];
    parse_state_e parse_state = ST_TEXT;
    logic [7:0]   kept_verb = 8'h00;   // negotiation verb or subcommand
    logic [7:0]   kept_opt  = 8'h00;   // subnegotiation option
    int           n_queued = 0;
    int           n_accepted = 0;
    int           fail_count = 0;

    // idling control, changed between phases
    int   src_idle_pct = 0;
    int   sink_stall_pct = 0;
    int   phase_no = 0;
    logic hold_off = 1'b0;

    result_t seen_beat;
    result_t want_beat;

    telnet_command_stream_parser i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // rx_byte
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // payload_byte, verb_code, option_code
        .m_tuser  (m_tuser),    // kind
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    function automatic result_t make_beat(input logic [2:0] kind, input logic [7:0] payload,
                                          input logic [7:0] verb, input logic [7:0] opt,
                                          input logic last);
        result_t r;
        r.kind         = kind;
        r.payload_byte = payload;
        r.verb_code    = verb;
        r.option_code  = opt;
        r.last         = last;
        return r;
    endfunction

    function automatic string beat_text(input result_t r);
        return $sformatf("kind %0d payload %02h verb %02h option %02h last %0d",
                         r.kind, r.payload_byte, r.verb_code, r.option_code, r.last);
    endfunction

    // telnet parsing of one accepted byte, queueing the result beats it gives
    task automatic parse_byte(input logic [7:0] b);
        case (parse_state)
            ST_IAC:
            begin
                if (b == CODE_IAC)
                begin
                    // escaped iac folds to one data byte
                    parse_state = ST_TEXT;
                    results_due.push_back(make_beat(KIND_DATA, 8'hFF, 8'h00, 8'h00, 1'b1));
                end
                else if (b >= CODE_WILL && b <= CODE_DONT)
                begin
                    kept_verb   = b;
                    parse_state = ST_OPT;
                end
                else if (b == CODE_SB)
                    parse_state = ST_SB_OPT;
                else
                    parse_state = ST_TEXT;   // unknown command, dropped silently
            end
            ST_OPT:
            begin
                parse_state = ST_TEXT;
                results_due.push_back(make_beat(KIND_NEG, 8'h00, kept_verb, b, 1'b1));
            end
            ST_SB_OPT:
            begin
                // header bytes are taken raw, even iac
                kept_opt    = b;
                parse_state = ST_SB_CMD;
            end
            ST_SB_CMD:
            begin
                kept_verb   = b;
                parse_state = ST_SB_ARG;
                results_due.push_back(make_beat(KIND_SBHDR, 8'h00, b, kept_opt, 1'b1));
            end
            ST_SB_ARG:
            begin
                if (b == CODE_IAC)
                    parse_state = ST_SB_IAC;
                else
                    results_due.push_back(make_beat(KIND_PARAM, b, kept_verb, kept_opt, 1'b1));
            end
            ST_SB_IAC:
            begin
                if (b == CODE_SE)
                begin
                    parse_state = ST_TEXT;
                    results_due.push_back(make_beat(KIND_SBEND, 8'h00, kept_verb, kept_opt,
                                                    1'b1));
                end
                else if (b == CODE_IAC)
                    // one 0xff parameter, the second iac may still open iac se
                    results_due.push_back(make_beat(KIND_PARAM, 8'hFF, kept_verb, kept_opt,
                                                    1'b1));
                else
                begin
                    // lone iac stays raw: two parameter beats from one byte
                    parse_state = ST_SB_ARG;
                    results_due.push_back(make_beat(KIND_PARAM, 8'hFF, kept_verb, kept_opt,
                                                    1'b0));
                    results_due.push_back(make_beat(KIND_PARAM, b, kept_verb, kept_opt, 1'b1));
                end
            end
            default:
            begin
                if (b == CODE_IAC)
                    parse_state = ST_IAC;
                else
                begin
                    parse_state = ST_TEXT;
                    results_due.push_back(make_beat(KIND_DATA, b, 8'h00, 8'h00, 1'b1));
                end
            end
        endcase
    endtask

    task automatic add_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        n_queued++;
    endtask

    // one random piece of telnet traffic, mostly well formed
    task automatic add_random_chunk();
        int sel;
        int n_args;
        int roll;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            add_byte(8'($urandom_range(0, 254)));
        else if (sel < 45)
        begin
            add_byte(CODE_IAC);
            add_byte(CODE_IAC);
        end
        else if (sel < 60)
        begin
            add_byte(CODE_IAC);
            add_byte(8'($urandom_range(CODE_WILL, CODE_DONT)));
            add_byte(8'($urandom_range(0, 255)));
        end
        else if (sel < 67)
        begin
            // command that is neither a verb nor sb nor iac
            add_byte(CODE_IAC);
            add_byte(8'($urandom_range(0, 249)));
        end
        else if (sel < 92)
        begin
            add_byte(CODE_IAC);
            add_byte(CODE_SB);
            add_byte(8'($urandom_range(0, 255)));
            add_byte(8'($urandom_range(0, 255)));
            n_args = $urandom_range(0, 6);
            for (int i = 0; i < n_args; i++)
            begin
                roll = $urandom_range(0, 9);
                if (roll < 6)
                    add_byte(8'($urandom_range(0, 254)));
                else if (roll < 8)
                begin
                    add_byte(CODE_IAC);
                    add_byte(CODE_IAC);
                end
                else
                begin
                    add_byte(CODE_IAC);
                    add_byte(8'($urandom_range(0, 239)));
                end
            end
            // now and then the se never comes and the subnegotiation stays open
            if ($urandom_range(0, 9) != 0)
            begin
                add_byte(CODE_IAC);
                add_byte(CODE_SE);
            end
        end
        else
            add_byte(8'($urandom_range(0, 255)));   // line noise
    endtask

    // every byte taken and every result beat seen, then a short tail
    task automatic wait_drained();
        while (!(n_accepted == n_queued && results_due.size() == 0))
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // byte driver: offers the next pending byte, predicting each accepted beat
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_byte(s_tdata);
                n_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_bytes.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor: random back-pressure, each beat checked against the oldest due
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen_beat = make_beat(m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
                                      m_tlast);
                if (results_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("unexpected result beat: %s", beat_text(seen_beat));
                end
                else
                begin
                    want_beat = results_due.pop_front();
                    if (seen_beat !== want_beat)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display("mismatch: expected %s, got %s",
                                     beat_text(want_beat), beat_text(seen_beat));
                    end
                end
            end
            m_tready <= !hold_off && ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // long receiver hold-off in the phase without idling, so the result queue fills
    initial
    begin
        while (phase_no != 1)
            @(posedge clk);
        repeat (20) @(posedge clk);
        hold_off <= 1'b1;
        repeat (80) @(posedge clk);
        hold_off <= 1'b0;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        logic [7:0] directed_seq [$];
        directed_seq = '{
            // plain data at the extremes
            8'h00, 8'h7F, 8'hFE,
            // escaped iac
            CODE_IAC, CODE_IAC,
            // all four verbs, options at the extremes
            CODE_IAC, CODE_WILL, 8'h00,
            CODE_IAC, CODE_WONT, 8'h01,
            CODE_IAC, CODE_DO, 8'h80,
            CODE_IAC, CODE_DONT, 8'hFF,
            // unknown commands, dropped
            CODE_IAC, CODE_NOP,
            CODE_IAC, CODE_SE,
            // header made of iac bytes, then a plain parameter
            CODE_IAC, CODE_SB, CODE_IAC, CODE_IAC, 8'h00,
            // lone iac gives two parameters, iac iac gives one, then se closes
            CODE_IAC, 8'h41, CODE_IAC, CODE_IAC, CODE_SE
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_seq[i])
            add_byte(directed_seq[i]);
        wait_drained();

        // random traffic over the idling phases: none, sender, receiver, both
        for (int ph = 1; ph <= 4; ph++)
        begin
            src_idle_pct   <= (ph == 2) ? 62 : (ph == 4) ? 22 : 0;
            sink_stall_pct <= (ph == 3) ? 62 : (ph == 4) ? 22 : 0;
            phase_no       <= ph;
            @(posedge clk);
            while (pending_bytes.size() < PHASE_BYTES)
                add_random_chunk();
            wait_drained();
        end

        repeat (16) @(posedge clk);
        if (fail_count == 0 && results_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
